[design/btfc_pkg.sv]
// ----------------------------------------------------------------------------
// btfc_pkg
// Shared types, constants and helper functions for the bit-stuffing
// transmit framer with CRC-8.
// ----------------------------------------------------------------------------
package btfc_pkg;

    // Field and datapath widths
    localparam int STUFF_W = 10;   // at most two stuffed zeros per payload byte
    localparam int NBITS_W = 4;    // holds a stuffed bit count of 8 to 10
    localparam int ACC_W   = 24;   // left-aligned packing accumulator
    localparam int ACNT_W  = 5;    // accumulator fill, at most 17
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CRASH_BIT_ENABLE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLLISION_MODE   = 8'd1;

    // Byte kinds
    localparam logic [1:0] KIND_FLAG = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_CRC  = 2'd2;
    localparam logic [1:0] KIND_COLL = 2'd3;

    // Framing constants
    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [7:0] COLL_BYTE   = 8'h3F;
    localparam logic [7:0] CRC_POLY    = 8'h31;
    localparam logic [7:0] CRC_INIT    = 8'hFF;
    localparam logic [7:0] CRASH_MASK  = 8'h10;
    localparam logic [1:0] CRASH_INDEX = 2'd2;
    localparam logic [1:0] OIDX_MAX    = 2'd3;
    localparam logic [2:0] STUFF_RUN   = 3'd5;
    localparam logic [1:0] COLL_LAST   = 2'd2;

    // Input transaction payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // Output transaction payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_kind;
        logic       frame_end;
        logic       run_last;
    } out_item_t;

    // Classified item passed from the front end to the back end
    typedef struct packed {
        logic               coll;       // collision marker burst
        logic               need_flag;  // first byte of a frame
        logic               last;       // closes the frame
        logic [STUFF_W-1:0] bits;       // stuffed bits, left-aligned
        logic [NBITS_W-1:0] nbits;      // number of valid bits in bits
    } qentry_t;

    // Back-end phases
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FLAG,
        BK_DATA,
        BK_PAD,
        BK_CRC,
        BK_COLL
    } bk_state_t;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_take(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Phase that follows once the accumulator holds cnt bits
    function automatic bk_state_t next_phase(input logic [ACNT_W-1:0] cnt, input logic last);
        bk_state_t ph;
        if (cnt >= ACNT_W'(8))
            ph = BK_DATA;
        else if (last)
            ph = (cnt != '0) ? BK_PAD : BK_CRC;
        else
            ph = BK_IDLE;
        return ph;
    endfunction

endpackage

[design/btfc_front.sv]
// ----------------------------------------------------------------------------
// btfc_front
// Accepts payload bytes, applies bit stuffing and classifies each byte
// into a queue entry for the back end, bar non-closing collision bytes.
// ----------------------------------------------------------------------------
module btfc_front
    import btfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     collision_mode,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     push,
    output qentry_t  push_entry,
    input  logic     push_ready
);

    logic [2:0] ones_run_reg;
    logic [2:0] ones_run_next;
    logic       in_frame_reg;
    logic       in_frame_next;
    logic       accept;
    logic [2:0] ones_after;
    logic [STUFF_W-1:0] stuffed;
    logic [NBITS_W-1:0] nstuffed;

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    // Bit stuffing over the eight payload bits, MSB first
    always_comb
    begin
        logic [2:0]         ones;
        logic [NBITS_W-1:0] n;
        logic [STUFF_W-1:0] bits;
        logic               b;
        ones = ones_run_reg;
        n    = '0;
        bits = '0;
        for (int i = 7; i >= 0; i--) begin
            b = in_data.data_byte[3'(i)];
            bits[NBITS_W'(STUFF_W - 1) - n] = b;
            n = n + 1'b1;
            if (b) begin
                ones = ones + 1'b1;
                if (ones == STUFF_RUN) begin
                    // stuffed zero: bits already cleared
                    n    = n + 1'b1;
                    ones = '0;
                end
            end else begin
                ones = '0;
            end
        end
        stuffed    = bits;
        nstuffed   = n;
        ones_after = ones;
    end

    // Queue entry
    always_comb
    begin
        push_entry.coll      = collision_mode;
        push_entry.need_flag = !in_frame_reg;
        push_entry.last      = in_data.last_byte;
        push_entry.bits      = stuffed;
        push_entry.nbits     = nstuffed;
    end

    // Collision bytes that do not close the frame are absorbed
    assign push = accept && !(collision_mode && !in_data.last_byte);

    // Frame tracking state
    always_comb
    begin
        ones_run_next = ones_run_reg;
        in_frame_next = in_frame_reg;
        if (accept) begin
            if (collision_mode) begin
                if (in_data.last_byte) begin
                    ones_run_next = '0;
                    in_frame_next = 1'b0;
                end
            end else begin
                ones_run_next = in_data.last_byte ? 3'd0 : ones_after;
                in_frame_next = !in_data.last_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ones_run_reg <= '0;
            in_frame_reg <= 1'b0;
        end else begin
            ones_run_reg <= ones_run_next;
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

[design/btfc_queue.sv]
// ----------------------------------------------------------------------------
// btfc_queue
// Short FIFO of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
module btfc_queue
    import btfc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  qentry_t push_entry,
    output logic    push_ready,
    output logic    head_valid,
    output qentry_t head_entry,
    input  logic    pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    qentry_t              entries_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];

    assign do_push = push && push_ready;
    assign do_pop  = pop && head_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

[design/btfc_back.sv]
// ----------------------------------------------------------------------------
// btfc_back
// Packs stuffed bits into bytes and emits flag, data, pad, CRC and collision
// marker bytes through an output register, one per cycle unless it stalls.
// ----------------------------------------------------------------------------
module btfc_back
    import btfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      crash_bit_enable,
    input  logic      head_valid,
    input  qentry_t   head_entry,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    bk_state_t          state_reg;
    bk_state_t          state_next;
    bk_state_t          phase_after;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic [ACNT_W-1:0]  cnt_reg;
    logic [ACNT_W-1:0]  cnt_next;
    logic [7:0]         crc_reg;
    logic [7:0]         crc_next;
    logic [1:0]         oidx_reg;
    logic [1:0]         oidx_next;
    logic [1:0]         coll_cnt_reg;
    logic [1:0]         coll_cnt_next;
    logic               last_reg;
    logic               last_next;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic               step_en;
    logic               emit;
    out_item_t          emit_item;
    logic [ACC_W-1:0]   post_acc;
    logic [ACNT_W-1:0]  post_cnt;
    logic [7:0]         post_crc;
    logic [1:0]         post_oidx;
    logic [1:0]         post_coll;

    // Output register is free or drains this cycle
    assign step_en   = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Phase after this cycle's byte, and next state including a load
    always_comb
    begin
        unique case (state_reg)
            BK_IDLE: phase_after = BK_IDLE;
            BK_FLAG: phase_after = next_phase(cnt_reg, last_reg);
            BK_DATA: phase_after = next_phase(cnt_reg - ACNT_W'(8), last_reg);
            BK_PAD:  phase_after = BK_CRC;
            BK_CRC:  phase_after = BK_IDLE;
            BK_COLL: phase_after = (coll_cnt_reg == COLL_LAST) ? BK_IDLE : BK_COLL;
            default: phase_after = BK_IDLE;
        endcase

        pop        = step_en && (phase_after == BK_IDLE) && head_valid;
        state_next = state_reg;
        if (step_en)
            state_next = phase_after;
        if (pop) begin
            if (head_entry.coll)
                state_next = BK_COLL;
            else if (head_entry.need_flag)
                state_next = BK_FLAG;
            else
                state_next = next_phase(cnt_next, head_entry.last);
        end
    end

    // Byte emission and framing datapath
    always_comb
    begin
        logic [7:0] raw;
        logic       framed;
        logic       clear;
        raw       = '0;
        framed    = 1'b0;
        clear     = 1'b0;
        emit      = 1'b0;
        emit_item = '0;
        post_acc  = acc_reg;
        post_cnt  = cnt_reg;
        post_crc  = crc_reg;
        post_oidx = oidx_reg;
        post_coll = coll_cnt_reg;

        case (state_reg)
            BK_FLAG:
            begin
                raw                 = FLAG_BYTE;
                framed              = 1'b1;
                emit_item.byte_kind = KIND_FLAG;
            end
            BK_DATA:
            begin
                raw                 = acc_reg[ACC_W-1 -: 8];
                framed              = 1'b1;
                emit_item.byte_kind = KIND_DATA;
                post_acc            = {acc_reg[ACC_W-9:0], 8'h00};
                post_cnt            = cnt_reg - ACNT_W'(8);
            end
            BK_PAD:
            begin
                raw                 = acc_reg[ACC_W-1 -: 8];
                framed              = 1'b1;
                emit_item.byte_kind = KIND_DATA;
                post_acc            = '0;
                post_cnt            = '0;
            end
            BK_CRC:
            begin
                raw                 = crc_reg;
                framed              = 1'b1;
                emit_item.byte_kind = KIND_CRC;
                emit_item.frame_end = 1'b1;
                clear               = 1'b1;
            end
            BK_COLL:
            begin
                emit                = 1'b1;
                emit_item.out_byte  = COLL_BYTE;
                emit_item.byte_kind = KIND_COLL;
                emit_item.frame_end = (coll_cnt_reg == COLL_LAST);
                post_coll           = coll_cnt_reg + 1'b1;
                clear               = (coll_cnt_reg == COLL_LAST);
            end
            default:
            begin
                raw = '0;
            end
        endcase

        // Framed bytes: CRC first, then optional crash inversion
        if (framed) begin
            emit = 1'b1;
            if (state_reg != BK_CRC)
                post_crc = crc8_take(crc_reg, raw);
            emit_item.out_byte = (crash_bit_enable && (oidx_reg == CRASH_INDEX)) ?
                                 (raw ^ CRASH_MASK) : raw;
            if (oidx_reg != OIDX_MAX)
                post_oidx = oidx_reg + 1'b1;
        end
        emit_item.run_last = (phase_after == BK_IDLE);

        // Frame closed or abandoned
        if (clear) begin
            post_acc  = '0;
            post_cnt  = '0;
            post_crc  = CRC_INIT;
            post_oidx = '0;
        end

        // Merge the next queue entry
        acc_next      = post_acc;
        cnt_next      = post_cnt;
        crc_next      = post_crc;
        oidx_next     = post_oidx;
        coll_cnt_next = post_coll;
        last_next     = last_reg;
        if (pop) begin
            last_next = head_entry.last;
            if (head_entry.coll) begin
                coll_cnt_next = '0;
            end else begin
                acc_next = post_acc |
                           ({head_entry.bits, {(ACC_W - STUFF_W){1'b0}}} >> post_cnt[2:0]);
                cnt_next = post_cnt + ACNT_W'(head_entry.nbits);
            end
        end
    end

    // Framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= BK_IDLE;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            crc_reg      <= CRC_INIT;
            oidx_reg     <= '0;
            coll_cnt_reg <= '0;
            last_reg     <= 1'b0;
        end else if (step_en) begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            crc_reg      <= crc_next;
            oidx_reg     <= oidx_next;
            coll_cnt_reg <= coll_cnt_next;
            last_reg     <= last_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_en)
            out_valid_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            out_data_reg <= emit_item;
    end

endmodule

[design/bit_stuff_tx_framer_crc8.sv]
// ----------------------------------------------------------------------------
// bit_stuff_tx_framer_crc8
// Transmit framer: flag, bit-stuffed payload, CRC-8, with error injection
// and collision marker modes.
// ----------------------------------------------------------------------------
// Path: the first byte caused by a transaction is registered in turn by the
//   queue write, the back-end load and the output register before it is valid.
// Throughput: one byte per cycle unless the output stalls; the next queued
//   item loads with an item's last byte.
// Reset: asynchronous, active low; clears framing state, CRC to 0xFF, both
//   configuration registers and the queue.
module bit_stuff_tx_framer_crc8
    import btfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic    crash_bit_enable_reg;
    logic    crash_bit_enable_next;
    logic    collision_mode_reg;
    logic    collision_mode_next;
    logic    push;
    logic    push_ready;
    qentry_t push_entry;
    logic    head_valid;
    qentry_t head_entry;
    logic    pop;

    // Configuration write decode
    assign cfg_ready = 1'b1;

    always_comb
    begin
        crash_bit_enable_next = crash_bit_enable_reg;
        collision_mode_next   = collision_mode_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CRASH_BIT_ENABLE: crash_bit_enable_next = cfg_data[0];
                REG_COLLISION_MODE:   collision_mode_next   = cfg_data[0];
                default:              crash_bit_enable_next = crash_bit_enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crash_bit_enable_reg <= 1'b0;
            collision_mode_reg   <= 1'b0;
        end else begin
            crash_bit_enable_reg <= crash_bit_enable_next;
            collision_mode_reg   <= collision_mode_next;
        end
    end

    // Front end: stuffing and classification
    btfc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .collision_mode (collision_mode_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .push           (push),
        .push_entry     (push_entry),
        .push_ready     (push_ready)
    );

    // Decoupling queue
    btfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    // Back end: packing, CRC and output
    btfc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .crash_bit_enable (crash_bit_enable_reg),
        .head_valid       (head_valid),
        .head_entry       (head_entry),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_data         (out_data)
    );

endmodule
